FILE: design/cwk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwk_pkg: shared types and constants for the CW keying pulse generator
// Command and pulse word layouts, opcodes, register indexes, timing limits.
// ----------------------------------------------------------------------------
package cwk_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
  localparam int COUNT_W      = SEG_AW + 1;

  localparam logic [16:0] GUARD_US        = 17'd1000;
  localparam logic [16:0] CHUNK_MAX_US    = 17'd100000;
  localparam logic [16:0] HALF_PERIOD_RST = 17'd625;
  localparam logic [18:0] TONE_NUM        = 19'd500000;
  localparam logic [15:0] TONE_DEFAULT    = 16'd800;
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_SEGMENTS);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_PULL  = 2'd2,
    OP_ABORT = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_STREAM = 2'd1,
    PH_TAIL   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  localparam logic CFG_MCW_MODE = 1'b0;
  localparam logic CFG_TONE_HZ  = 1'b1;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  seg_index;
    logic        seg_on;
    logic [31:0] seg_len_us;
    logic [8:0]  seg_count;
  } cmd_t;

  typedef struct packed {
    logic        level;
    logic [16:0] span_us;
    logic        stream_end;
    logic [31:0] run_us;
  } pulse_t;

endpackage

FILE: design/cw_keying_pulse_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cw_keying_pulse_generator_top: Morse segment list to keying pulse stream
// Holds up to 256 on/off segments and hands out level/duration pulses on
// request, with guard pulses, OOK chunking or MCW square-wave tone.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | word
//  --------+-----+------------------------+--------------------------------
//  cmd     | in  | cmd_valid / cmd_stall  | cwk_pkg::cmd_t (load/start/pull/abort)
//  pulse   | out | pulse_valid/pulse_stall| cwk_pkg::pulse_t (one per pull)
//  cfg     | in  | cfg_we                 | cfg_index, cfg_data (mode, tone)
//
// Sequencing: load and abort are taken in idle and leave the sequencer idle.
// A start runs accept plus a 19-step restoring divide of 500000 by the tone,
// one quotient bit a cycle. A pull passes PULL then EMIT for a guard or end
// mark and PULL, SUB, EMIT for a pulse, plus PULL and FETCH per segment
// fetched from the store (address, then registered read data), so each
// zero-length segment adds that pair; EMIT waits on a stalled output word.
// Reset: synchronous; control clears at once, the segment store is not
// cleared (no clearing pass). Pulse words wait in the output register while
// the downstream stalls; cmd words are taken whenever the sequencer is idle.
// ----------------------------------------------------------------------------
module cw_keying_pulse_generator_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  cwk_pkg::cmd_t   cmd,
  output logic            pulse_valid,
  input  logic            pulse_stall,
  output cwk_pkg::pulse_t pulse,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data
);

  // sequencer, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_PULL  = 6'b000100,
    S_FETCH = 6'b001000,
    S_SUB   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;

  // configuration registers
  logic        mcw_mode;
  logic [15:0] tone_hz;

  // stream state
  logic [cwk_pkg::COUNT_W-1:0] segment_total;
  logic [cwk_pkg::COUNT_W-1:0] next_index;
  logic [31:0]                 remaining_time;
  logic                        current_on;
  logic                        tone_phase;
  logic [16:0]                 half_period;
  logic [31:0]                 elapsed_time;
  cwk_pkg::phase_t             stream_phase;
  logic                        abort_flag;
  logic                        mode_latched;

  // divider
  logic [15:0] divisor;
  logic [15:0] div_rem;
  logic [18:0] quot;
  logic [4:0]  div_bit;

  // pulse being formed
  logic [16:0]     pulse_dur;
  logic            pulse_level;
  cwk_pkg::pulse_t res;

  // segment store: {on, duration}
  logic [32:0] seg_mem [cwk_pkg::MAX_SEGMENTS];
  logic [32:0] seg_q;

  logic cmd_accept;
  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;

  // output register takes the formed word once it is free
  logic pulse_load;
  assign pulse_load = (state == S_EMIT) && (!pulse_valid || !pulse_stall);

  always_ff @(posedge clk) begin
    if (cmd_accept && cmd.opcode == cwk_pkg::OP_LOAD) begin
      seg_mem[cmd.seg_index[cwk_pkg::SEG_AW-1:0]] <= {cmd.seg_on, cmd.seg_len_us};
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PULL) begin
      seg_q <= seg_mem[next_index[cwk_pkg::SEG_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mcw_mode <= 1'b0;
      tone_hz  <= cwk_pkg::TONE_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cwk_pkg::CFG_MCW_MODE: mcw_mode <= cfg_data[0];
        cwk_pkg::CFG_TONE_HZ:  tone_hz  <= cfg_data;
        default: ;
      endcase
    end
  end

  // one restoring-divide step: shift in the next dividend bit, try subtract
  logic [16:0] div_shift;
  logic        div_ge;
  logic [18:0] quot_next;
  assign div_shift = {div_rem, cwk_pkg::TONE_NUM[div_bit]};
  assign div_ge    = (div_shift >= {1'b0, divisor});
  assign quot_next = {quot[17:0], div_ge};

  // pulse length: burst half-period for an MCW on segment, chunk limit otherwise, capped at the time left
  logic        tone_burst;
  logic [16:0] dur_limit;
  logic [16:0] dur_pick;
  assign tone_burst = mode_latched && current_on;
  assign dur_limit  = tone_burst ? half_period : cwk_pkg::CHUNK_MAX_US;
  assign dur_pick   = (remaining_time < {15'd0, dur_limit}) ? remaining_time[16:0]
                                                             : dur_limit;

  logic [31:0] elapsed_next;
  assign elapsed_next = elapsed_time + {15'd0, pulse_dur};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      segment_total  <= '0;
      next_index     <= '0;
      remaining_time <= '0;
      current_on     <= 1'b0;
      tone_phase     <= 1'b0;
      half_period    <= cwk_pkg::HALF_PERIOD_RST;
      elapsed_time   <= '0;
      stream_phase   <= cwk_pkg::PH_DONE;
      abort_flag     <= 1'b0;
      mode_latched   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            unique case (cmd.opcode)
              cwk_pkg::OP_LOAD: ;
              cwk_pkg::OP_START: begin
                if (cmd.seg_count != '0) begin
                  segment_total  <= (cmd.seg_count > 9'(cwk_pkg::MAX_SEGMENTS))
                                    ? cwk_pkg::COUNT_MAX
                                    : cwk_pkg::COUNT_W'(cmd.seg_count);
                  next_index     <= '0;
                  remaining_time <= '0;
                  current_on     <= 1'b0;
                  tone_phase     <= 1'b0;
                  elapsed_time   <= '0;
                  stream_phase   <= cwk_pkg::PH_LEAD;
                  abort_flag     <= 1'b0;
                  mode_latched   <= mcw_mode;
                  divisor        <= (tone_hz == '0) ? cwk_pkg::TONE_DEFAULT : tone_hz;
                  div_rem        <= '0;
                  quot           <= '0;
                  div_bit        <= 5'd18;
                  state          <= S_DIV;
                end
              end
              cwk_pkg::OP_PULL:  state <= S_PULL;
              cwk_pkg::OP_ABORT: abort_flag <= 1'b1;
              default: ;
            endcase
          end
        end

        S_DIV: begin
          div_rem <= div_ge ? 16'(div_shift - {1'b0, divisor}) : div_shift[15:0];
          quot    <= quot_next;
          div_bit <= div_bit - 5'd1;
          if (div_bit == 5'd0) begin
            // tones under 5 Hz saturate at the chunk limit
            half_period <= (quot_next > {2'b00, cwk_pkg::CHUNK_MAX_US})
                           ? cwk_pkg::CHUNK_MAX_US : quot_next[16:0];
            state <= S_IDLE;
          end
        end

        S_PULL: begin
          if (stream_phase == cwk_pkg::PH_LEAD) begin
            // lead guard goes out even after an abort
            stream_phase <= cwk_pkg::PH_STREAM;
            res   <= '{level: 1'b1, span_us: cwk_pkg::GUARD_US,
                       stream_end: 1'b0, run_us: elapsed_time};
            state <= S_EMIT;
          end else if (abort_flag) begin
            res   <= '{level: 1'b0, span_us: 17'd0,
                       stream_end: 1'b1, run_us: elapsed_time};
            state <= S_EMIT;
          end else if (remaining_time == '0) begin
            if (next_index >= segment_total) begin
              if (stream_phase == cwk_pkg::PH_STREAM) begin
                stream_phase <= cwk_pkg::PH_TAIL;
                res <= '{level: 1'b1, span_us: cwk_pkg::GUARD_US,
                         stream_end: 1'b0, run_us: elapsed_time};
              end else begin
                stream_phase <= cwk_pkg::PH_DONE;
                res <= '{level: 1'b0, span_us: 17'd0,
                         stream_end: 1'b1, run_us: elapsed_time};
              end
              state <= S_EMIT;
            end else begin
              // store read issued this cycle, data lands in FETCH
              next_index <= next_index + cwk_pkg::COUNT_W'(1);
              state      <= S_FETCH;
            end
          end else begin
            pulse_dur   <= dur_pick;
            pulse_level <= tone_burst ? tone_phase : (!mode_latched && current_on);
            if (tone_burst) begin
              tone_phase <= !tone_phase;
            end
            state <= S_SUB;
          end
        end

        S_FETCH: begin
          remaining_time <= seg_q[31:0];
          current_on     <= seg_q[32];
          if (!seg_q[32]) begin
            tone_phase <= 1'b0;   // next burst starts low
          end
          state <= S_PULL;
        end

        S_SUB: begin
          remaining_time <= remaining_time - {15'd0, pulse_dur};
          elapsed_time   <= elapsed_next;
          res   <= '{level: pulse_level, span_us: pulse_dur,
                     stream_end: 1'b0, run_us: elapsed_next};
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (pulse_load) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_valid <= 1'b0;
    end else if (pulse_load) begin
      pulse_valid <= 1'b1;
    end else if (!pulse_stall) begin
      pulse_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pulse_load) begin
      pulse <= res;
    end
  end

endmodule

FILE: tb/sv/cw_keying_pulse_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cw_keying_pulse_generator_top_tb: self-checking bench for the keying generator
// Loads segment lists, arms streams and pulls pulses under random handshake
// gaps and stalls, in OOK and MCW at several tones. A behavioral copy of the
// keyer predicts every pulse word, which is checked field by field.
// ----------------------------------------------------------------------------
module cw_keying_pulse_generator_top_tb;

  // Phases of the random part, each with its own mode and tone setting.
  localparam int        NUM_PHASES   = 8;
  localparam int        PHASE_WORDS  = 215;
  localparam logic [7:0] MCW_PHASES  = 8'b0110_1110;
  // A start gives no pulse and runs its divide first; wait well past it.
  localparam int        QUIET_CYCLES = 40;
  localparam int        STREAM_PULLS = 120;

  // Behavioral state of the keyer: store, stream position, tone, settings.
  typedef struct packed {
    logic [cwk_pkg::MAX_SEGMENTS-1:0][32:0] store;
    logic [8:0]  total;
    logic [8:0]  next_seg;
    logic [31:0] remaining;
    logic        cur_on;
    logic        tone_hi;
    logic [31:0] half;
    logic [31:0] elapsed;
    cwk_pkg::phase_t phase;
    logic        aborted;
    logic        mcw_latched;
    logic        mcw_reg;
    logic [15:0] tone_reg;
  } keyer_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cmd_valid = 1'b0;
  logic            cmd_stall;
  cwk_pkg::cmd_t   cmd = '0;
  logic            pulse_valid;
  logic            pulse_stall = 1'b0;
  cwk_pkg::pulse_t pulse;
  logic            cfg_we = 1'b0;
  logic            cfg_index = 1'b0;
  logic [15:0]     cfg_data = 16'd0;

  // Two copies of the keyer: one runs ahead while words are planned (it
  // tells when a stream has ended), the other follows accepted words and
  // feeds the queue of pulses still due from the block.
  keyer_t          plan_keyer;
  keyer_t          live_keyer;
  cwk_pkg::cmd_t   cmd_backlog[$];
  cwk_pkg::pulse_t due_pulses[$];
  int              items_made = 0;
  int              failures = 0;

  logic            live_got;
  cwk_pkg::pulse_t live_pulse;
  cwk_pkg::pulse_t want;

  int burst_left = 0;
  int idle_left = 0;
  int stall_style = 0;
  int stall_span = 0;
  logic [3:0] stall_tick = 4'd0;

  cw_keying_pulse_generator_top dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .pulse_valid (pulse_valid),
    .pulse_stall (pulse_stall),
    .pulse       (pulse),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Keyer prediction
  // --------------------------------------------------------------------------
  function automatic keyer_t keyer_reset();
    keyer_t k;
    k = '0;
    k.half     = 32'(cwk_pkg::HALF_PERIOD_RST);
    k.phase    = cwk_pkg::PH_DONE;
    k.tone_reg = cwk_pkg::TONE_DEFAULT;
    return k;
  endfunction

  // One command word; a pull always yields exactly one pulse word.
  task automatic key_pulse_step(inout keyer_t k, input cwk_pkg::cmd_t c,
                                output logic got, output cwk_pkg::pulse_t p);
    logic [31:0] dur;
    logic [31:0] hp;
    logic [15:0] tone;
    logic        lvl;
    got = 1'b0;
    p = '0;
    case (c.opcode)
      cwk_pkg::OP_LOAD: k.store[c.seg_index] = {c.seg_on, c.seg_len_us};
      cwk_pkg::OP_START: begin
        // Zero count is refused outright.
        if (c.seg_count != 9'd0) begin
          tone = (k.tone_reg != 16'd0) ? k.tone_reg : cwk_pkg::TONE_DEFAULT;
          hp = 32'(cwk_pkg::TONE_NUM) / {16'd0, tone};
          if (hp > 32'(cwk_pkg::CHUNK_MAX_US)) hp = 32'(cwk_pkg::CHUNK_MAX_US);
          k.total       = (c.seg_count > cwk_pkg::COUNT_MAX) ? cwk_pkg::COUNT_MAX
                                                             : c.seg_count;
          k.next_seg    = 9'd0;
          k.remaining   = 32'd0;
          k.cur_on      = 1'b0;
          k.tone_hi     = 1'b0;
          k.half        = hp;
          k.elapsed     = 32'd0;
          k.phase       = cwk_pkg::PH_LEAD;
          k.aborted     = 1'b0;
          k.mcw_latched = k.mcw_reg;
        end
      end
      cwk_pkg::OP_ABORT: k.aborted = 1'b1;
      default: begin
        got = 1'b1;
        if (k.phase == cwk_pkg::PH_LEAD) begin
          // Lead guard goes out even after an abort.
          k.phase = cwk_pkg::PH_STREAM;
          p.level = 1'b1;
          p.span_us = cwk_pkg::GUARD_US;
        end else begin
          // Fetch past zero-length segments.
          while (!k.aborted && k.remaining == 32'd0 && k.next_seg < k.total) begin
            {k.cur_on, k.remaining} = k.store[k.next_seg[7:0]];
            k.next_seg = k.next_seg + 9'd1;
            if (!k.cur_on) k.tone_hi = 1'b0;
          end
          if (k.aborted) begin
            p.stream_end = 1'b1;
          end else if (k.remaining == 32'd0) begin
            if (k.phase == cwk_pkg::PH_STREAM) begin
              k.phase = cwk_pkg::PH_TAIL;
              p.level = 1'b1;
              p.span_us = cwk_pkg::GUARD_US;
            end else begin
              k.phase = cwk_pkg::PH_DONE;
              p.stream_end = 1'b1;
            end
          end else begin
            if (k.mcw_latched && k.cur_on) begin
              dur = (k.half > k.remaining) ? k.remaining : k.half;
              lvl = k.tone_hi;
              k.tone_hi = ~k.tone_hi;
            end else begin
              dur = (k.remaining > 32'(cwk_pkg::CHUNK_MAX_US)) ? 32'(cwk_pkg::CHUNK_MAX_US)
                                                               : k.remaining;
              lvl = ~k.mcw_latched & k.cur_on;
            end
            k.remaining = k.remaining - dur;
            k.elapsed   = k.elapsed + dur;
            p.level = lvl;
            p.span_us = dur[16:0];
          end
        end
        p.run_us = k.elapsed;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Word planning
  // --------------------------------------------------------------------------
  // Fields a command does not use carry random bits.
  function automatic cwk_pkg::cmd_t word_of(cwk_pkg::opcode_t op);
    cwk_pkg::cmd_t c;
    c.opcode     = op;
    c.seg_index  = 8'($urandom);
    c.seg_on     = 1'($urandom);
    c.seg_len_us = $urandom;
    c.seg_count  = 9'($urandom);
    return c;
  endfunction

  task automatic issue(input cwk_pkg::cmd_t c, output cwk_pkg::pulse_t p);
    logic got;
    key_pulse_step(plan_keyer, c, got, p);
    cmd_backlog.push_back(c);
    items_made++;
  endtask

  task automatic send_load(input logic [7:0] idx, input logic on, input logic [31:0] dur);
    cwk_pkg::cmd_t   c;
    cwk_pkg::pulse_t p;
    c = word_of(cwk_pkg::OP_LOAD);
    c.seg_index = idx;
    c.seg_on = on;
    c.seg_len_us = dur;
    issue(c, p);
  endtask

  task automatic send_start(input logic [8:0] cnt);
    cwk_pkg::cmd_t   c;
    cwk_pkg::pulse_t p;
    c = word_of(cwk_pkg::OP_START);
    c.seg_count = cnt;
    issue(c, p);
  endtask

  task automatic send_abort();
    cwk_pkg::pulse_t p;
    issue(word_of(cwk_pkg::OP_ABORT), p);
  endtask

  task automatic send_pull(output cwk_pkg::pulse_t p);
    issue(word_of(cwk_pkg::OP_PULL), p);
  endtask

  task automatic pull_until_end(input int budget, output logic ended);
    cwk_pkg::pulse_t p;
    int              n;
    n = 0;
    ended = 1'b0;
    while (!ended && n < budget) begin
      send_pull(p);
      ended = p.stream_end;
      n++;
    end
  endtask

  // Mostly Morse-like lengths, some around the chunk limit, a few huge.
  function automatic logic [31:0] pick_duration();
    case ($urandom_range(0, 9)) inside
      0:       return 32'd0;
      [1:5]:   return 32'($urandom_range(1, 2000));
      6:       return 32'($urandom_range(2001, 20000));
      7:       return 32'(cwk_pkg::CHUNK_MAX_US) + 32'($urandom_range(0, 2)) - 32'd1;
      8:       return 32'($urandom_range(100002, 400000));
      default: return $urandom;
    endcase
  endfunction

  // One random episode: usually load a short list, start, pull to the end;
  // now and then a stray word of any kind.
  task automatic random_episode();
    cwk_pkg::pulse_t p;
    logic            ended;
    int              k;
    int              cnt;
    int              budget;
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       send_load(8'($urandom), 1'($urandom), pick_duration());
        1:       send_start(9'($urandom));
        2:       send_pull(p);
        default: send_abort();
      endcase
    end else begin
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int i = 0; i < k; i++) send_load(8'(i), 1'($urandom), pick_duration());
      // Sometimes run on into older slots, up past the store size.
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(k, 511) : k;
      send_start(9'(cnt));
      case ($urandom_range(0, 9))
        0: begin
          // restart in mid-stream
          pull_until_end($urandom_range(1, 3), ended);
          send_start(9'(cnt));
        end
        1: send_start(9'd0);
        default: ;
      endcase
      budget = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : STREAM_PULLS;
      pull_until_end(budget, ended);
      if (!ended) begin
        send_abort();
        send_pull(p);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Configuration and idle detection
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cwk_pkg::CFG_MCW_MODE) begin
      plan_keyer.mcw_reg = val[0];
      live_keyer.mcw_reg = val[0];
    end else begin
      plan_keyer.tone_reg = val;
      live_keyer.tone_reg = val;
    end
  endtask

  // Sampled on the falling edge so the driver's updates have settled.
  task automatic settle();
    while (cmd_backlog.size() != 0 || cmd_valid || due_pulses.size() != 0)
      @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] phase_tone(int ph);
    case (ph)
      0:       return 16'd0;
      1:       return cwk_pkg::TONE_DEFAULT;
      2:       return 16'd1;
      3:       return 16'hFFFF;
      4:       return 16'd5;
      5:       return 16'd4;
      6:       return 16'($urandom_range(200, 3000));
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Command driver: bursts of random length with random gaps. The live keyer
  // steps on every accepted word, so expectations follow acceptance order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        key_pulse_step(live_keyer, cmd, live_got, live_pulse);
        if (live_got) due_pulses.push_back(live_pulse);
      end
      if (!cmd_valid || !cmd_stall) begin
        if (idle_left != 0 || cmd_backlog.size() == 0) begin
          cmd_valid <= 1'b0;
          if (idle_left != 0) idle_left--;
        end else begin
          cmd       <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            // a quarter of bursts run straight into the next
            idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pulse stall: switches at random intervals between no stall, light random
  // stall, a square pattern from a free-running counter, and heavy stall.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 300);
    end else begin
      stall_span--;
    end
    case (stall_style)
      0:       pulse_stall <= 1'b0;
      1:       pulse_stall <= ($urandom_range(0, 2) == 0);
      2:       pulse_stall <= stall_tick[3];
      default: pulse_stall <= ($urandom_range(0, 9) != 0);
    endcase
    stall_tick <= stall_tick + 4'd1;
  end

  // --------------------------------------------------------------------------
  // Pulse monitor
  // --------------------------------------------------------------------------
  // Printing stops after 200 errors; the count goes on.
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      if (failures < 200)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pulse_valid && !pulse_stall) begin
      if (due_pulses.size() == 0) begin
        if (failures < 200)
          $display("%0t: pulse word with none due, expected nothing, got %h", $time, pulse);
        failures++;
      end else begin
        want = due_pulses.pop_front();
        check_field("level", 32'(want.level), 32'(pulse.level));
        check_field("span_us", 32'(want.span_us), 32'(pulse.span_us));
        check_field("stream_end", 32'(want.stream_end), 32'(pulse.stream_end));
        check_field("run_us", want.run_us, pulse.run_us);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    cwk_pkg::pulse_t p;
    int              target;
    plan_keyer = keyer_reset();
    live_keyer = keyer_reset();

    // Pull before any stream: end mark.
    send_pull(p);
    // Fill the whole store so that any count only reads written slots.
    for (int i = 0; i < cwk_pkg::MAX_SEGMENTS; i++) send_load(8'(i), 1'(i), 32'd0);

    // Directed words, at reset settings (OOK, 800 Hz).
    // Longest segment, chunked, then aborted: end mark from then on.
    send_load(8'd0, 1'b1, 32'hFFFF_FFFF);
    send_start(9'd1);
    send_pull(p);
    send_pull(p);
    send_pull(p);
    send_abort();
    send_pull(p);
    // Zero count is refused, so the abort still holds.
    send_start(9'd0);
    send_pull(p);
    // Count over the store size saturates; zero-length slots are skipped.
    send_load(8'd0, 1'b1, 32'd100001);
    send_load(8'd1, 1'b0, 32'd0);
    send_load(8'd2, 1'b0, 32'd1);
    send_start(9'd511);
    send_pull(p);
    send_pull(p);
    // Restart in mid-stream, then run to the tail guard and end mark.
    send_start(9'd3);
    for (int i = 0; i < 6; i++) send_pull(p);
    // Abort right after start: lead guard first, then end mark.
    send_start(9'd2);
    send_abort();
    send_pull(p);
    send_pull(p);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(cwk_pkg::CFG_MCW_MODE, {15'($urandom), MCW_PHASES[ph]});
      write_reg(cwk_pkg::CFG_TONE_HZ, phase_tone(ph));
      @(negedge clk);
      target = items_made + PHASE_WORDS;
      while (items_made < target) random_episode();
      settle();
    end

    if (failures == 0 && due_pulses.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Hang guard, far past the slowest legal run.
  initial begin
    #60_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: cw_keying_pulse_generator_top.f
design/cwk_pkg.sv
design/cw_keying_pulse_generator_top.sv
tb/sv/cw_keying_pulse_generator_top_tb.sv
